@@ hw/rtl/scg_pkg.sv @@
`default_nettype none
package scg_pkg;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN_INC  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] GOLDEN_INC2 = GOLDEN_INC + GOLDEN_INC;
	localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

	// FNV-1a
	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

	// role tags: "salt" followed by 'R' or 'S'
	localparam logic [31:0] TAG_STEM   = 32'h7361_6C74;
	localparam logic [7:0]  TAG_CHAR_R = 8'h52;
	localparam logic [7:0]  TAG_CHAR_S = 8'h53;
	localparam int          TAG_LEN    = 5;

	localparam int WORDS_OUT_DEF = 4;

	// position info that travels with each word
	typedef struct packed {
		logic [1:0] word_index;
		logic       last_word;
	} word_tag_t;

	// FNV-1a over the five tag bytes; used for elaboration-time constants only
	function automatic logic [63:0] tag_hash(input logic [7:0] last_char);
		logic [63:0] h;
		logic [39:0] tag;
		h   = FNV_BASIS;
		tag = {TAG_STEM, last_char};
		for (int k = 0; k < TAG_LEN; k++) begin
			h = h ^ {56'd0, tag[39 - 8 * k -: 8]};
			h = h * FNV_PRIME;
		end
		return h;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/scg_query_if.sv @@
`default_nettype none
interface scg_query_if;
	logic        valid;
	logic        ready;
	logic [63:0] seed_value;
	logic        role_is_sender;
	logic [63:0] query_number;

	modport source (output valid, seed_value, role_is_sender, query_number, input ready);
	modport sink   (input valid, seed_value, role_is_sender, query_number, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/scg_salt_if.sv @@
`default_nettype none
interface scg_salt_if;
	logic        valid;
	logic        ready;
	logic [63:0] salt_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, salt_word, word_index, last_word, input ready);
	modport sink   (input valid, salt_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/salt_contribution_generator.sv @@
// The first salt word passes the seed register, the expander register and mix
// stages m1 to m4; the rest follow one per cycle when the sink keeps ready high.
// Throughput is set by the single output channel, one word per cycle while the sink
// keeps ready high; a new request is taken as the last word leaves the expander.
// Reset (arst_n low): all valid bits and the word counter clear; no clearing pass,
// the block takes requests as soon as reset is released.
`default_nettype none
module salt_contribution_generator
	import scg_pkg::*;
#(
	parameter int WORDS_OUT = WORDS_OUT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	scg_query_if.sink  query,
	scg_salt_if.source salt
);

	// seed stage -> word expander
	logic        seeded_valid;
	logic        seeded_ready;
	logic [63:0] seeded_state;
	logic [63:0] seeded_query;

	// word expander -> mixing pipeline
	logic        word_valid;
	logic        word_ready;
	logic [63:0] word_state;
	word_tag_t   word_tag;

	// Stage s1: seed xor role tag hash, plus the first generator advance.
	scg_seed u_seed (
		.clk          (clk),
		.arst_n       (arst_n),
		.query        (query),
		.seeded_valid (seeded_valid),
		.seeded_ready (seeded_ready),
		.seeded_state (seeded_state),
		.seeded_query (seeded_query)
	);

	// Holds one request and walks the generator state once per output word.
	// Frees up on the cycle its last word moves on, so requests run back to back.
	scg_expand #(
		.WORDS_OUT (WORDS_OUT)
	) u_expand (
		.clk          (clk),
		.arst_n       (arst_n),
		.seeded_valid (seeded_valid),
		.seeded_ready (seeded_ready),
		.seeded_state (seeded_state),
		.seeded_query (seeded_query),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.word_state   (word_state),
		.word_tag     (word_tag)
	);

	// Four-stage output mix; each 64-bit multiply is split into 32x32 partial
	// products and summed in the following stage. Stages collapse bubbles,
	// the last stage is the output register.
	scg_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_state (word_state),
		.word_tag   (word_tag),
		.salt       (salt)
	);

endmodule
`default_nettype wire

@@ hw/rtl/scg_seed.sv @@
`default_nettype none
module scg_seed
	import scg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	scg_query_if.sink        query,
	output logic             seeded_valid,
	input  wire logic        seeded_ready,
	output logic [63:0]      seeded_state,
	output logic [63:0]      seeded_query
);

	localparam logic [63:0] HASH_R = tag_hash(TAG_CHAR_R);
	localparam logic [63:0] HASH_S = tag_hash(TAG_CHAR_S);

	logic        v_s1;
	logic [63:0] state_s1;
	logic [63:0] query_s1;
	logic [63:0] hash_c;

	assign query.ready = !v_s1 || seeded_ready;
	assign hash_c      = query.role_is_sender ? HASH_S : HASH_R;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (query.ready) begin
			v_s1 <= query.valid;
		end
	end

	// first step: only the state advance matters, its output is dropped
	always_ff @(posedge clk) begin
		if (query.ready) begin
			state_s1 <= (query.seed_value ^ hash_c) + GOLDEN_INC;
			query_s1 <= query.query_number;
		end
	end

	assign seeded_valid = v_s1;
	assign seeded_state = state_s1;
	assign seeded_query = query_s1;

endmodule
`default_nettype wire

@@ hw/rtl/scg_expand.sv @@
`default_nettype none
module scg_expand
	import scg_pkg::*;
#(
	parameter int WORDS_OUT = WORDS_OUT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seeded_valid,
	output logic             seeded_ready,
	input  wire logic [63:0] seeded_state,
	input  wire logic [63:0] seeded_query,
	output logic             word_valid,
	input  wire logic        word_ready,
	output logic [63:0]      word_state,
	output word_tag_t        word_tag
);

	localparam int CNT_W = (WORDS_OUT > 1) ? $clog2(WORDS_OUT) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORDS_OUT - 1);

	logic             busy_q;
	logic [63:0]      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W+1:0] cnt_ext;
	logic             last_c;
	logic             take_c;
	logic             done_c;
	logic             load_c;

	assign last_c       = (cnt_q == CNT_LAST);
	assign take_c       = busy_q && word_ready;
	assign done_c       = take_c && last_c;
	assign seeded_ready = !busy_q || done_c;
	assign load_c       = seeded_valid && seeded_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load_c) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done_c) begin
			busy_q <= 1'b0;
		end else if (take_c) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// second discarded step plus the first output step folded into one add
	always_ff @(posedge clk) begin
		if (load_c) begin
			state_q <= (seeded_state ^ seeded_query) + GOLDEN_INC2;
		end else if (take_c) begin
			state_q <= state_q + GOLDEN_INC;
		end
	end

	assign cnt_ext             = {2'b00, cnt_q};
	assign word_valid          = busy_q;
	assign word_state          = state_q;
	assign word_tag.word_index = cnt_ext[1:0];
	assign word_tag.last_word  = last_c;

endmodule
`default_nettype wire

@@ hw/rtl/scg_mix.sv @@
`default_nettype none
module scg_mix
	import scg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        word_valid,
	output logic             word_ready,
	input  wire logic [63:0] word_state,
	input  wire word_tag_t   word_tag,
	scg_salt_if.source       salt
);

	// m1: xor-shift, partial products with A; m2: sum
	// m3: xor-shift, partial products with B; m4: sum, final xor-shift
	logic        v_m1, v_m2, v_m3, v_m4;
	logic        acc_m1, acc_m2, acc_m3, acc_m4;
	logic [63:0] ll_m1, ll_m3;
	logic [31:0] lh_m1, hl_m1, lh_m3, hl_m3;
	logic [63:0] p_m2, word_m4;
	word_tag_t   tag_m1, tag_m2, tag_m3, tag_m4;

	logic [63:0] z1_c, z2_c, q_c;

	assign acc_m4     = !v_m4 || salt.ready;
	assign acc_m3     = !v_m3 || acc_m4;
	assign acc_m2     = !v_m2 || acc_m3;
	assign acc_m1     = !v_m1 || acc_m2;
	assign word_ready = acc_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
		end else begin
			if (acc_m1) v_m1 <= word_valid;
			if (acc_m2) v_m2 <= v_m1;
			if (acc_m3) v_m3 <= v_m2;
			if (acc_m4) v_m4 <= v_m3;
		end
	end

	assign z1_c = word_state ^ (word_state >> 30);
	assign z2_c = p_m2 ^ (p_m2 >> 27);
	assign q_c  = ll_m3 + {lh_m3 + hl_m3, 32'd0};

	always_ff @(posedge clk) begin
		if (acc_m1) begin
			ll_m1  <= 64'(z1_c[31:0]) * 64'(MIX_MUL_A[31:0]);
			lh_m1  <= z1_c[31:0] * MIX_MUL_A[63:32];
			hl_m1  <= z1_c[63:32] * MIX_MUL_A[31:0];
			tag_m1 <= word_tag;
		end
		if (acc_m2) begin
			p_m2   <= ll_m1 + {lh_m1 + hl_m1, 32'd0};
			tag_m2 <= tag_m1;
		end
		if (acc_m3) begin
			ll_m3  <= 64'(z2_c[31:0]) * 64'(MIX_MUL_B[31:0]);
			lh_m3  <= z2_c[31:0] * MIX_MUL_B[63:32];
			hl_m3  <= z2_c[63:32] * MIX_MUL_B[31:0];
			tag_m3 <= tag_m2;
		end
		if (acc_m4) begin
			word_m4 <= q_c ^ (q_c >> 31);
			tag_m4  <= tag_m3;
		end
	end

	assign salt.valid      = v_m4;
	assign salt.salt_word  = word_m4;
	assign salt.word_index = tag_m4.word_index;
	assign salt.last_word  = tag_m4.last_word;

endmodule
`default_nettype wire

@@ tb/sv/tb_salt_contribution_generator.sv @@
`timescale 1ns / 1ps

module tb_salt_contribution_generator;
	import scg_pkg::*;

	// Generator constants, kept local so the prediction does not lean on the package math.
	localparam logic [63:0] WEYL_STEP   = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] FINAL_MUL_A = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] FINAL_MUL_B = 64'h94D0_49BB_1331_11EB;
	localparam logic [63:0] FNV_OFFSET  = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] FNV_MULT    = 64'h0000_0100_0000_01B3;
	localparam logic [7:0]  CHAR_RECEIVER = 8'h52;	// 'R'
	localparam logic [7:0]  CHAR_SENDER   = 8'h53;	// 'S'

	localparam int SALT_WORDS    = WORDS_OUT_DEF;
	localparam int RANDOM_COUNT  = 170;
	localparam int REPORT_LIMIT  = 10;
	// Worst case per request: an idle gap on the query side, the pipeline latency,
	// and four words each behind a sink stall; the limit sits several times above
	// that sum over the ~190 requests.
	localparam int CYCLE_LIMIT   = 400_000;

	typedef struct {
		logic [63:0] seed_value;
		logic        role_is_sender;
		logic [63:0] query_number;
	} salt_request_t;

	typedef struct packed {
		logic [63:0] salt_word;
		logic [1:0]  word_index;
		logic        last_word;
	} salt_word_t;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	// Everything the testbench drives has a known value from time zero.
	logic        q_valid = 1'b0;
	logic [63:0] q_seed  = '0;
	logic        q_role  = 1'b0;
	logic [63:0] q_query = '0;
	logic        s_ready = 1'b0;

	scg_query_if query_ch ();
	scg_salt_if  salt_ch ();

	assign query_ch.valid          = q_valid;
	assign query_ch.seed_value     = q_seed;
	assign query_ch.role_is_sender = q_role;
	assign query_ch.query_number   = q_query;
	assign salt_ch.ready           = s_ready;

	salt_contribution_generator uut (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query_ch),
		.salt  (salt_ch)
	);

	// Scoreboard state
	salt_request_t pending_requests[$];
	salt_word_t    expected_words[$];
	salt_request_t cur_req;

	int accepted_count = 0;
	int total_requests = 0;
	int directed_count = 0;
	int words_checked  = 0;
	int mismatches     = 0;
	int cycle_count    = 0;

	// Idle-length state per side; a nonzero calm count forces back-to-back traffic.
	int src_gap   = 0;
	int src_calm  = 0;
	int sink_left = 0;
	int sink_calm = 0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly short gaps, some long ones, now and then a calm stretch with none at all.
	function automatic int idle_length(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// 64-bit FNV-1a over "salt" plus the role character.
	function automatic logic [63:0] role_tag_hash(input logic [7:0] role_char);
		logic [7:0]  tag_bytes [5];
		logic [63:0] h;
		tag_bytes = '{8'h73, 8'h61, 8'h6C, 8'h74, role_char};
		h = FNV_OFFSET;
		for (int k = 0; k < 5; k++) begin
			h = h ^ {56'd0, tag_bytes[k]};
			h = h * FNV_MULT;
		end
		return h;
	endfunction

	// One splitmix64 advance: bump the state, return the finalized word.
	task automatic splitmix_advance(inout logic [63:0] st, output logic [63:0] word);
		logic [63:0] z;
		st = st + WEYL_STEP;
		z  = st;
		z  = (z ^ (z >> 30)) * FINAL_MUL_A;
		z  = (z ^ (z >> 27)) * FINAL_MUL_B;
		word = z ^ (z >> 31);
	endtask

	// Queue up the four salt words an accepted request must produce.
	task automatic predict_salt(input salt_request_t req);
		logic [63:0] st;
		logic [63:0] word;
		salt_word_t  exp;
		st = req.seed_value ^ role_tag_hash(req.role_is_sender ? CHAR_SENDER : CHAR_RECEIVER);
		splitmix_advance(st, word);	// first output discarded
		st = st ^ req.query_number;
		splitmix_advance(st, word);	// second output discarded
		for (int w = 0; w < SALT_WORDS; w++) begin
			splitmix_advance(st, word);
			exp.salt_word  = word;
			exp.word_index = w[1:0];
			exp.last_word  = (w == SALT_WORDS - 1);
			expected_words.push_back(exp);
		end
	endtask

	// Query driver: holds a request until it is taken, then waits out a random
	// gap before presenting the next one. Payload is noise while valid is low.
	always @(posedge clk) begin : query_driver
		logic presenting;
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else begin
			presenting = q_valid;
			if (q_valid && query_ch.ready) begin
				predict_salt(cur_req);
				accepted_count++;
				presenting = 1'b0;
				src_gap = idle_length(src_calm);
			end
			if (!presenting) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending_requests.size() != 0) begin
					cur_req    = pending_requests.pop_front();
					presenting = 1'b1;
				end
			end
			q_valid <= presenting;
			if (presenting) begin
				q_seed  <= cur_req.seed_value;
				q_role  <= cur_req.role_is_sender;
				q_query <= cur_req.query_number;
			end else begin
				q_seed  <= rand64();
				q_role  <= 1'($urandom_range(0, 1));
				q_query <= rand64();
			end
		end
	end

	// Salt monitor: checks every accepted word against the oldest expectation,
	// and throttles ready with random stalls.
	always @(posedge clk) begin : salt_monitor
		salt_word_t exp;
		logic       ready_nxt;
		if (!arst_n) begin
			s_ready <= 1'b0;
		end else begin
			if (salt_ch.valid && s_ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("[%0t] unexpected salt word %h idx %0d last %0b", $realtime,
							salt_ch.salt_word, salt_ch.word_index, salt_ch.last_word);
				end else begin
					exp = expected_words.pop_front();
					words_checked++;
					if (salt_ch.salt_word !== exp.salt_word ||
					    salt_ch.word_index !== exp.word_index ||
					    salt_ch.last_word !== exp.last_word) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("[%0t] salt mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
								$realtime, exp.salt_word, exp.word_index, exp.last_word,
								salt_ch.salt_word, salt_ch.word_index, salt_ch.last_word);
					end
				end
			end
			// A stall starts only from a ready cycle, so ready is always high again between
			// stalls; calm stretches keep it high throughout.
			if (sink_left > 0) begin
				sink_left--;
				ready_nxt = 1'b0;
			end else begin
				ready_nxt = 1'b1;
				if ($urandom_range(0, 3) == 0)
					sink_left = idle_length(sink_calm);
			end
			s_ready <= ready_nxt;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d requests taken, %0d words pending",
				cycle_count, accepted_count, total_requests, expected_words.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		salt_request_t req;
		logic [63:0]   corner_vals [6];

		// Directed part: corner seeds against corner query numbers, both roles.
		corner_vals = '{64'h0, '1, 64'h1, 64'h8000_0000_0000_0000,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
		for (int i = 0; i < 6; i++) begin
			for (int role = 0; role < 2; role++) begin
				req.seed_value     = corner_vals[i];
				req.role_is_sender = role[0];
				req.query_number   = corner_vals[5 - i];
				pending_requests.push_back(req);
			end
		end
		// All-zero and all-one requests in each role
		for (int role = 0; role < 2; role++) begin
			req.role_is_sender = role[0];
			req.seed_value     = '0;
			req.query_number   = '0;
			pending_requests.push_back(req);
			req.seed_value     = '1;
			req.query_number   = '1;
			pending_requests.push_back(req);
		end
		directed_count = pending_requests.size();

		// Random part: full-range seeds; query numbers are often small counters,
		// as they would be in use, and otherwise full range.
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			req.seed_value     = rand64();
			req.role_is_sender = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: req.query_number = 64'(i);
				1: req.query_number = 64'($urandom_range(0, 255));
				default: req.query_number = rand64();
			endcase
			pending_requests.push_back(req);
		end
		total_requests = pending_requests.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_requests)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		// Let any stray extra word show up before closing.
		repeat (20) @(posedge clk);

		$display("%0d requests (%0d directed, %0d random) over both roles, %0d salt words checked",
			total_requests, directed_count, total_requests - directed_count, words_checked);
		$display("%0d mismatching or unexpected words, %0d cycles", mismatches, cycle_count);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
